// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while rst is high
`define CHK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// next-cycle implication, disabled while rst is high
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

// File: rtl/lbfs_pkg.sv
`timescale 1ns / 1ps

package lbfs_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_CUT_MODE  = 3'd0;
  localparam logic [2:0] REG_DELIMITER = 3'd1;
  localparam logic [2:0] REG_KEEP      = 3'd2;
  localparam logic [2:0] REG_RANGE_A   = 3'd3;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;
  localparam logic [7:0] TAB_BYTE     = 8'd9;

  // what the single closing byte of a request is
  typedef logic [1:0] tail_kind_t;
  localparam tail_kind_t TAIL_NL    = 2'd0;
  localparam tail_kind_t TAIL_DELIM = 2'd1;
  localparam tail_kind_t TAIL_BYTE  = 2'd2;

  // output register source
  localparam logic OUT_SRC_STORE = 1'b0;
  localparam logic OUT_SRC_TAIL  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       sel_cur_en;
    logic       sel_nxt_en;
    logic       inc_pos;
    logic       inc_field;
    logic       set_delim_seen;
    logic       set_printed;
    logic       store_wr;
    logic       set_overflow;
    logic       clear_line;
    logic       rd_start;
    logic       rd_en;
    logic       rd_inc;
    logic       out_load;
    logic       out_src;
    logic       out_last;
    tail_kind_t tail_kind;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_nl;
    logic is_delim;
    logic mode;
    logic keep;
    logic delim_seen;
    logic printed;
    logic sel_cur;
    logic sel_nxt;
    logic len_zero;
    logic len_full;
    logic rd_last;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/lbfs_datapath.sv
`timescale 1ns / 1ps

module lbfs_datapath #(
  parameter int FIRST_FIELD_DEPTH = 63,
  parameter int RANGE_COUNT       = 8,
  parameter int COUNT_BITS        = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  input  logic [7:0]          s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,
  output logic                m_tlast,
  output logic [0:0]          m_tuser,
  input  lbfs_pkg::cmd_t      cmd,
  output lbfs_pkg::stat_t     stat
);

  localparam int LEN_W = $clog2(FIRST_FIELD_DEPTH + 1);
  localparam int IDX_W = (FIRST_FIELD_DEPTH > 1) ? $clog2(FIRST_FIELD_DEPTH) : 1;
  localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  // configuration registers
  logic                  cut_mode;
  logic [7:0]            delimiter;
  logic                  keep_undelimited;

  // line state
  logic [COUNT_BITS-1:0] position_count;
  logic [COUNT_BITS-1:0] field_count;
  logic                  delimiter_seen;
  logic                  anything_printed;
  logic [LEN_W-1:0]      first_field_length;
  logic                  overflow_flag;

  // per-request registers
  logic [7:0]            byte_reg;
  logic [COUNT_BITS-1:0] probe;
  logic                  sel_cur;
  logic                  sel_nxt;
  logic [LEN_W-1:0]      rd_idx;
  logic [7:0]            rd_data;
  logic [7:0]            store_mem [FIRST_FIELD_DEPTH];

  logic [COUNT_BITS-1:0] pos_inc;
  logic [COUNT_BITS-1:0] field_inc;
  logic [RANGE_COUNT-1:0] lane_hit;
  logic                  probe_sel;
  logic [7:0]            tail_byte;

  assign pos_inc   = (&position_count) ? position_count : position_count + 1'b1;
  assign field_inc = (&field_count) ? field_count : field_count + 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cut_mode         <= 1'b0;
      delimiter        <= lbfs_pkg::TAB_BYTE;
      keep_undelimited <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == lbfs_pkg::REG_CUT_MODE) cut_mode <= cfg_data[0];
      if (cfg_index == lbfs_pkg::REG_DELIMITER) delimiter <= cfg_data[7:0];
      if (cfg_index == lbfs_pkg::REG_KEEP) keep_undelimited <= cfg_data[0];
    end
  end

  // range lanes: each compares the probe against one range
  for (genvar k = 0; k < RANGE_COUNT; k++) begin : g_lane
    localparam logic [2:0] LANE_REG = lbfs_pkg::REG_RANGE_A + 3'(k / 2);
    localparam int         LANE_SH  = (k % 2) * 32;
    logic [15:0]      range_lo;
    logic [15:0]      range_hi;
    logic [CMP_W-1:0] lo_ext;
    logic [CMP_W-1:0] hi_ext;
    logic [CMP_W-1:0] p_ext;

    always_ff @(posedge clk) begin
      if (rst) begin
        range_lo <= '0;
        range_hi <= '0;
      end else if (cfg_we && cfg_index == LANE_REG) begin
        range_lo <= cfg_data[LANE_SH +: 16];
        range_hi <= cfg_data[LANE_SH + 16 +: 16];
      end
    end

    assign lo_ext = CMP_W'(range_lo);
    assign hi_ext = CMP_W'(range_hi);
    assign p_ext  = CMP_W'(probe);
    assign lane_hit[k] = (range_lo != 16'd0) && (lo_ext <= p_ext) &&
                         ((range_hi == 16'd0) || (p_ext <= hi_ext));
  end

  assign probe_sel = |lane_hit;

  // input byte, probe and selection results
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      byte_reg <= s_tdata;
      probe    <= cut_mode ? field_count : pos_inc;
    end
    if (cmd.sel_cur_en) begin
      sel_cur <= probe_sel;
      probe   <= field_inc;
    end
    if (cmd.sel_nxt_en) sel_nxt <= probe_sel;
  end

  // line state updates
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_line) begin
      position_count     <= '0;
      field_count        <= COUNT_BITS'(1);
      delimiter_seen     <= 1'b0;
      anything_printed   <= 1'b0;
      first_field_length <= '0;
      overflow_flag      <= 1'b0;
    end else begin
      if (cmd.inc_pos) position_count <= pos_inc;
      if (cmd.inc_field) field_count <= field_inc;
      if (cmd.set_delim_seen) delimiter_seen <= 1'b1;
      if (cmd.set_printed) anything_printed <= 1'b1;
      if (cmd.store_wr) first_field_length <= first_field_length + 1'b1;
      if (cmd.set_overflow) overflow_flag <= 1'b1;
    end
  end

  // field-one store
  always_ff @(posedge clk) begin
    if (cmd.store_wr) store_mem[first_field_length[IDX_W-1:0]] <= byte_reg;
    if (cmd.rd_en) rd_data <= store_mem[rd_idx[IDX_W-1:0]];
  end

  // flush read index
  always_ff @(posedge clk) begin
    if (cmd.rd_start) rd_idx <= '0;
    else if (cmd.rd_inc) rd_idx <= rd_idx + 1'b1;
  end

  // closing byte of a request
  always_comb begin
    case (cmd.tail_kind)
      lbfs_pkg::TAIL_DELIM: tail_byte = delimiter;
      lbfs_pkg::TAIL_BYTE:  tail_byte = byte_reg;
      default:              tail_byte = lbfs_pkg::NEWLINE_BYTE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata    <= (cmd.out_src == lbfs_pkg::OUT_SRC_STORE) ? rd_data : tail_byte;
      m_tlast    <= cmd.out_last;
      m_tuser[0] <= overflow_flag;
    end
  end

  // status to the controller
  always_comb begin
    stat.is_nl      = byte_reg == lbfs_pkg::NEWLINE_BYTE;
    stat.is_delim   = byte_reg == delimiter;
    stat.mode       = cut_mode;
    stat.keep       = keep_undelimited;
    stat.delim_seen = delimiter_seen;
    stat.printed    = anything_printed;
    stat.sel_cur    = sel_cur;
    stat.sel_nxt    = sel_nxt;
    stat.len_zero   = first_field_length == '0;
    stat.len_full   = first_field_length == LEN_W'(FIRST_FIELD_DEPTH);
    stat.rd_last    = rd_idx == first_field_length - 1'b1;
    stat.out_free   = !m_tvalid || m_tready;
  end

endmodule

// File: rtl/lbfs_ctrl.sv
`timescale 1ns / 1ps

module lbfs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  lbfs_pkg::stat_t stat,
  output lbfs_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEL1 = 3'd1;
  localparam logic [2:0] S_SEL2 = 3'd2;
  localparam logic [2:0] S_DO   = 3'd3;
  localparam logic [2:0] S_FRD  = 3'd4;
  localparam logic [2:0] S_FOUT = 3'd5;
  localparam logic [2:0] S_TAIL = 3'd6;

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic                 tail_pend;
  logic                 tail_pend_next;
  lbfs_pkg::tail_kind_t tail_kind;
  lbfs_pkg::tail_kind_t tail_kind_next;

  logic first_delim_sel;

  assign s_tready = state == S_IDLE;

  // first delimiter of a line that closes a selected field one
  assign first_delim_sel = !stat.delim_seen && stat.sel_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tail_pend <= 1'b0;
      tail_kind <= lbfs_pkg::TAIL_NL;
    end else begin
      state     <= state_next;
      tail_pend <= tail_pend_next;
      tail_kind <= tail_kind_next;
    end
  end

  // sequencing and commands
  always_comb begin
    state_next     = state;
    tail_pend_next = tail_pend;
    tail_kind_next = tail_kind;
    cmd            = '0;
    cmd.tail_kind  = tail_kind;
    cmd.out_src    = lbfs_pkg::OUT_SRC_TAIL;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_SEL1;
        end
      end
      S_SEL1: begin
        cmd.sel_cur_en = 1'b1;
        state_next     = S_SEL2;
      end
      S_SEL2: begin
        cmd.sel_nxt_en = 1'b1;
        state_next     = S_DO;
      end
      S_DO: begin
        tail_pend_next = 1'b0;
        state_next     = S_IDLE;
        cmd.rd_start   = 1'b1;
        if (stat.is_nl) begin
          tail_kind_next = lbfs_pkg::TAIL_NL;
          if (!stat.mode || stat.delim_seen) begin
            state_next = S_TAIL;
          end else if (stat.keep) begin
            tail_pend_next = 1'b1;
            state_next     = stat.len_zero ? S_TAIL : S_FRD;
          end else begin
            // undelimited line dropped
            cmd.clear_line = 1'b1;
          end
        end else begin
          cmd.inc_pos = 1'b1;
          if (!stat.mode) begin
            tail_kind_next = lbfs_pkg::TAIL_BYTE;
            if (stat.sel_cur) state_next = S_TAIL;
          end else if (stat.is_delim) begin
            cmd.inc_field      = 1'b1;
            cmd.set_delim_seen = 1'b1;
            cmd.set_printed    = stat.printed || first_delim_sel || stat.sel_nxt;
            tail_kind_next     = lbfs_pkg::TAIL_DELIM;
            tail_pend_next     = stat.sel_nxt && (stat.printed || first_delim_sel);
            if (first_delim_sel && !stat.len_zero) state_next = S_FRD;
            else if (tail_pend_next) state_next = S_TAIL;
          end else if (!stat.delim_seen) begin
            // field one goes to the store until it is full
            cmd.store_wr     = !stat.len_full;
            cmd.set_overflow = stat.len_full;
          end else begin
            tail_kind_next = lbfs_pkg::TAIL_BYTE;
            if (stat.sel_cur) state_next = S_TAIL;
          end
        end
      end
      S_FRD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_FOUT;
      end
      S_FOUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = lbfs_pkg::OUT_SRC_STORE;
          cmd.out_last = stat.rd_last && !tail_pend;
          cmd.rd_inc   = 1'b1;
          if (stat.rd_last) state_next = tail_pend ? S_TAIL : S_IDLE;
          else state_next = S_FRD;
        end
      end
      S_TAIL: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_last   = 1'b1;
          cmd.clear_line = tail_kind == lbfs_pkg::TAIL_NL;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/line_byte_field_selector_core.sv
`timescale 1ns / 1ps
// channel   direction  signals                         contents
// s_        in         s_tvalid s_tready s_tdata       in_byte
// m_        out        m_tvalid m_tready m_tdata/last  out_byte, run_end, overflow_seen
// cfg_      in         cfg_we cfg_index cfg_data       register writes, no read-back
//
// each input byte steps through accept, two range-lane lookups and decide;
// a closing byte adds a tail step; each byte flushed from the field-one store
// adds a read step and an output step, since its read port is registered.
// rst is synchronous; line state and registers return to their reset values
// at once, the store needs no clearing.
// a stalled output holds the sequencer; a new byte is taken while the last
// result of the previous one still waits in the output register.

module line_byte_field_selector_core #(
  parameter int FIRST_FIELD_DEPTH = 63,
  parameter int RANGE_COUNT       = 8,
  parameter int COUNT_BITS        = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,
  output logic [0:0]  m_tuser,   // [0] overflow_seen
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  lbfs_pkg::cmd_t  cmd;
  lbfs_pkg::stat_t stat;

  // sequencer
  lbfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // counters, ranges, store and output register
  lbfs_datapath #(
    .FIRST_FIELD_DEPTH (FIRST_FIELD_DEPTH),
    .RANGE_COUNT       (RANGE_COUNT),
    .COUNT_BITS        (COUNT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// File: rtl/lbfs_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lbfs_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [0:0] m_tuser
);

  // whole result beat, for the hold check
  logic [9:0] out_beat;

  assign out_beat = {m_tdata, m_tlast, m_tuser};

  // a stalled result holds its contents
  `CHK_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(out_beat))

  // one byte at a time: no request taken in the cycle after one is taken
  `CHK_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready)

  // reset leaves the output empty
  `CHK_IMPLY(a_reset_empty, clk, 1'b0, $past(rst), !m_tvalid)

endmodule

bind line_byte_field_selector_core lbfs_checker u_lbfs_checker (.*);
